[design/wsd_pkg.sv]
// shared types and constants for the websocket frame deframer
`default_nettype none

package wsd_pkg;

    typedef enum logic [2:0] {
        PH_HDR0  = 3'd0,
        PH_HDR1  = 3'd1,
        PH_EXT16 = 3'd2,
        PH_EXT64 = 3'd3,
        PH_MASK  = 3'd4,
        PH_BODY  = 3'd5,
        PH_DONE  = 3'd6
    } phase_t;

    typedef enum logic [1:0] {
        KIND_DATA  = 2'd0,
        KIND_EMPTY = 2'd1,
        KIND_ABORT = 2'd2
    } kind_t;

    typedef struct packed {
        kind_t       kind;
        logic [7:0]  payload_byte;
        logic        final_fragment;
        logic [3:0]  opcode;
        logic        is_masked;
        logic [63:0] frame_length;
        logic        last_of_payload;
    } res_t;

    localparam logic [6:0] LEN16_CODE  = 7'd126;
    localparam logic [6:0] LEN64_CODE  = 7'd127;
    localparam logic [3:0] EXT16_BYTES = 4'd2;
    localparam logic [3:0] EXT64_BYTES = 4'd8;
    localparam logic [3:0] MASK_BYTES  = 4'd4;

endpackage

`default_nettype wire

[design/wsd_in_if.sv]
// received byte channel
`default_nettype none

interface wsd_in_if;
    logic       valid;
    logic       ready;
    logic [7:0] data_byte;
    logic       buffer_end;

    modport source (output valid, output data_byte, output buffer_end, input ready);
    modport sink (input valid, input data_byte, input buffer_end, output ready);
endinterface

`default_nettype wire

[design/wsd_out_if.sv]
// decoded result channel
`default_nettype none

interface wsd_out_if;
    logic        valid;
    logic        ready;
    logic [1:0]  kind;
    logic [7:0]  payload_byte;
    logic        final_fragment;
    logic [3:0]  opcode;
    logic        is_masked;
    logic [63:0] frame_length;
    logic        last_of_payload;

    modport source (
        output valid, output kind, output payload_byte, output final_fragment,
        output opcode, output is_masked, output frame_length,
        output last_of_payload, input ready
    );
    modport sink (
        input valid, input kind, input payload_byte, input final_fragment,
        input opcode, input is_masked, input frame_length,
        input last_of_payload, output ready
    );
endinterface

`default_nettype wire

[design/wsd_in_reg.sv]
// input register stage for received bytes
`default_nettype none

module wsd_in_reg (
    input  wire logic  clk,
    input  wire logic  rst_n,
    wsd_in_if.sink     rx,
    input  wire logic  take,
    output logic       held_valid,
    output logic [7:0] held_byte,
    output logic       held_end
);

    logic       valid_reg;
    logic       valid_next;
    logic [7:0] byte_reg;
    logic       end_reg;
    logic       load;

    assign rx.ready   = !valid_reg || take;
    assign load       = rx.valid && rx.ready;
    assign valid_next = load ? 1'b1 : (take ? 1'b0 : valid_reg);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            byte_reg <= rx.data_byte;
            end_reg  <= rx.buffer_end;
        end
    end

    assign held_valid = valid_reg;
    assign held_byte  = byte_reg;
    assign held_end   = end_reg;

endmodule

`default_nettype wire

[design/wsd_parser.sv]
// frame header decoder, unmasking and frame state
`default_nettype none

module wsd_parser
    import wsd_pkg::*;
#(
    parameter int LENGTH_BITS = 64
) (
    input  wire logic       clk,
    input  wire logic       rst_n,
    input  wire logic       fire,
    input  wire logic [7:0] data_byte,
    input  wire logic       buffer_end,
    output logic            res_valid,
    output res_t            res
);

    phase_t                   phase_reg, phase_next;
    logic [3:0]               hidx_reg, hidx_next;
    logic [LENGTH_BITS-1:0]   len_reg, len_next;
    logic [31:0]              key_reg, key_next;
    logic [LENGTH_BITS-1:0]   cnt_reg, cnt_next;
    logic                     fin_reg, fin_next;
    logic [3:0]               op_reg, op_next;
    logic                     masked_reg, masked_next;

    logic                     go_after;
    logic                     go_body;
    logic [7:0]               key_byte;
    logic [3:0]               need;
    kind_t                    res_kind;
    logic [7:0]               res_byte;
    logic                     res_last;

    always_comb
    begin
        case (cnt_reg[1:0])
            2'd0:    key_byte = key_reg[31:24];
            2'd1:    key_byte = key_reg[23:16];
            2'd2:    key_byte = key_reg[15:8];
            default: key_byte = key_reg[7:0];
        endcase
    end

    always_comb
    begin
        phase_next  = phase_reg;
        hidx_next   = hidx_reg;
        len_next    = len_reg;
        key_next    = key_reg;
        cnt_next    = cnt_reg;
        fin_next    = fin_reg;
        op_next     = op_reg;
        masked_next = masked_reg;
        go_after    = 1'b0;
        go_body     = 1'b0;
        res_valid   = 1'b0;
        res_kind    = KIND_DATA;
        res_byte    = 8'd0;
        res_last    = 1'b0;
        need        = (phase_reg == PH_EXT16) ? EXT16_BYTES : EXT64_BYTES;

        case (phase_reg)
            PH_HDR0:
            begin
                fin_next    = data_byte[7];
                op_next     = data_byte[3:0];
                masked_next = 1'b0;
                len_next    = '0;
                key_next    = '0;
                cnt_next    = '0;
                hidx_next   = '0;
                phase_next  = PH_HDR1;
            end
            PH_HDR1:
            begin
                masked_next = data_byte[7];
                hidx_next   = '0;
                len_next    = '0;
                if (data_byte[6:0] == LEN16_CODE)
                begin
                    phase_next = PH_EXT16;
                end
                else if (data_byte[6:0] == LEN64_CODE)
                begin
                    phase_next = PH_EXT64;
                end
                else
                begin
                    len_next = LENGTH_BITS'(data_byte[6:0]);
                    go_after = 1'b1;
                end
            end
            PH_EXT16, PH_EXT64:
            begin
                len_next  = {len_reg[LENGTH_BITS-9:0], data_byte};
                hidx_next = hidx_reg + 4'd1;
                if (hidx_next >= need)
                begin
                    go_after = 1'b1;
                end
            end
            PH_MASK:
            begin
                key_next  = {key_reg[23:0], data_byte};
                hidx_next = hidx_reg + 4'd1;
                if (hidx_next >= MASK_BYTES)
                begin
                    hidx_next = '0;
                    go_body   = 1'b1;
                end
            end
            PH_BODY:
            begin
                cnt_next  = cnt_reg + LENGTH_BITS'(1);
                res_valid = 1'b1;
                res_kind  = KIND_DATA;
                res_byte  = data_byte ^ (masked_reg ? key_byte : 8'd0);
                res_last  = (cnt_next == len_reg);
                if (res_last)
                begin
                    phase_next = PH_DONE;
                end
            end
            default:
            begin
                phase_next = PH_DONE;
            end
        endcase

        if (go_after)
        begin
            hidx_next = '0;
            if (masked_next)
            begin
                phase_next = PH_MASK;
            end
            else
            begin
                go_body = 1'b1;
            end
        end

        if (go_body)
        begin
            if (len_next == '0)
            begin
                phase_next = PH_DONE;
                res_valid  = 1'b1;
                res_kind   = KIND_EMPTY;
                res_byte   = 8'd0;
                res_last   = 1'b1;
            end
            else
            begin
                cnt_next   = '0;
                phase_next = PH_BODY;
            end
        end

        if (buffer_end)
        begin
            if (phase_next != PH_DONE)
            begin
                res_valid = 1'b1;
                res_kind  = KIND_ABORT;
                res_byte  = 8'd0;
                res_last  = 1'b0;
            end
            phase_next = PH_HDR0;
            hidx_next  = '0;
        end
    end

    assign res.kind            = res_kind;
    assign res.payload_byte    = res_byte;
    assign res.final_fragment  = fin_next;
    assign res.opcode          = op_next;
    assign res.is_masked       = masked_next;
    assign res.frame_length    = 64'(len_next);
    assign res.last_of_payload = res_last;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg  <= PH_HDR0;
            hidx_reg   <= '0;
            len_reg    <= '0;
            key_reg    <= '0;
            cnt_reg    <= '0;
            fin_reg    <= 1'b0;
            op_reg     <= '0;
            masked_reg <= 1'b0;
        end
        else if (fire)
        begin
            phase_reg  <= phase_next;
            hidx_reg   <= hidx_next;
            len_reg    <= len_next;
            key_reg    <= key_next;
            cnt_reg    <= cnt_next;
            fin_reg    <= fin_next;
            op_reg     <= op_next;
            masked_reg <= masked_next;
        end
    end

endmodule

`default_nettype wire

[design/wsd_out_reg.sv]
// result register driving the output channel
`default_nettype none

module wsd_out_reg
    import wsd_pkg::*;
(
    input  wire logic  clk,
    input  wire logic  rst_n,
    input  wire logic  load,
    input  wire res_t  res,
    output logic       space,
    wsd_out_if.source  result
);

    logic valid_reg;
    logic valid_next;
    res_t res_reg;

    assign space      = !valid_reg || result.ready;
    assign valid_next = load ? 1'b1 : (result.ready ? 1'b0 : valid_reg);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            res_reg <= res;
        end
    end

    assign result.valid           = valid_reg;
    assign result.kind            = res_reg.kind;
    assign result.payload_byte    = res_reg.payload_byte;
    assign result.final_fragment  = res_reg.final_fragment;
    assign result.opcode          = res_reg.opcode;
    assign result.is_masked       = res_reg.is_masked;
    assign result.frame_length    = res_reg.frame_length;
    assign result.last_of_payload = res_reg.last_of_payload;

endmodule

`default_nettype wire

[design/websocket_frame_deframer_unit.sv]
// websocket frame deframer top level
//
//  channel  dir  handshake     item
//  rx       in   valid/ready   data_byte, buffer_end
//  result   out  valid/ready   kind, payload_byte, header fields, last_of_payload
//
// one byte per clock sustained while result is not stalled; the byte waits in the input register
// input register, single-pass decode, then result register
// a byte is decoded only when the result register is free or being emptied
// rst_n clears the frame state to expect a first header byte
`default_nettype none

module websocket_frame_deframer_unit
    import wsd_pkg::*;
#(
    parameter int LENGTH_BITS = 64
) (
    input  wire logic  clk,
    input  wire logic  rst_n,
    wsd_in_if.sink     rx,
    wsd_out_if.source  result
);

    logic       held_valid;
    logic [7:0] held_byte;
    logic       held_end;
    logic       space;
    logic       fire;
    logic       res_valid;
    res_t       res;

    assign fire = held_valid && space;

    wsd_in_reg u_in_reg (
        .clk        (clk),
        .rst_n      (rst_n),
        .rx         (rx),
        .take       (fire),
        .held_valid (held_valid),
        .held_byte  (held_byte),
        .held_end   (held_end)
    );

    wsd_parser #(
        .LENGTH_BITS (LENGTH_BITS)
    ) u_parser (
        .clk        (clk),
        .rst_n      (rst_n),
        .fire       (fire),
        .data_byte  (held_byte),
        .buffer_end (held_end),
        .res_valid  (res_valid),
        .res        (res)
    );

    wsd_out_reg u_out_reg (
        .clk    (clk),
        .rst_n  (rst_n),
        .load   (fire && res_valid),
        .res    (res),
        .space  (space),
        .result (result)
    );

endmodule

`default_nettype wire
